FILE: src/khtl_pkg.sv
package khtl_pkg;

  // field widths of the request and result
  localparam int unsigned CharW   = 8;
  localparam int unsigned TokW    = 8;
  localparam int unsigned StatusW = 2;

  // hash multiplier 31 is applied as (hash << 5) - hash
  localparam int unsigned HashShift = 5;

  // result status codes
  typedef enum logic [StatusW-1:0] {
    StHit      = 2'd0,
    StMiss     = 2'd1,
    StInserted = 2'd2,
    StFull     = 2'd3
  } status_e;

  // control from the sequencer to the hash unit
  typedef struct packed {
    logic             step;
    logic             clear;
    logic [CharW-1:0] char_code;
  } hash_req_t;

endpackage

FILE: src/keyword_hash_table_lookup.sv
// Keyword hash table: words arrive one character per request, the last one
// flagged; the word-end request looks the word up or inserts it with a token
// in an open-addressed table with linear probing. After reset the block is
// busy while it clears the slot table. A character is accepted, then passes
// through the hash fold. At the word end a setup step comes first, then for
// every slot probed a slot memory read and a check, with one more read and
// check when the whole table was walked without a free slot or a match, a
// read and a check for every character compared on a length match, and for
// an insert a read and a write per stored character, then a slot write; the
// word buffer and slot memories each give one read a cycle. Exactly one
// result, marked by done_o for a single cycle, follows each word-end request;
// results cannot be held off by the receiver.
module keyword_hash_table_lookup #(
  parameter int unsigned TABLE_ENTRIES    = 64,
  parameter int unsigned MAX_STORED_CHARS = 31
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic                            opcode_i,
  input  logic [khtl_pkg::CharW-1:0]      char_code_i,
  input  logic                            last_char_i,
  input  logic [khtl_pkg::TokW-1:0]       token_code_i,
  output logic                            done_o,
  output logic [khtl_pkg::StatusW-1:0]    status_o,
  output logic [khtl_pkg::TokW-1:0]       found_token_o
);

  import khtl_pkg::*;

  localparam int unsigned SlotW   = $clog2(TABLE_ENTRIES);
  localparam int unsigned ProbeW  = SlotW + 1;
  localparam int unsigned LenW    = $clog2(MAX_STORED_CHARS + 2);
  localparam int unsigned SLenW   = $clog2(MAX_STORED_CHARS + 1);
  localparam int unsigned BufAw   = (MAX_STORED_CHARS > 1) ? $clog2(MAX_STORED_CHARS) : 1;
  localparam int unsigned CharsD  = TABLE_ENTRIES * MAX_STORED_CHARS;
  localparam int unsigned CharsAw = $clog2(CharsD);
  localparam int unsigned MetaW   = 1 + SLenW + TokW;

  localparam logic [SlotW-1:0]   LastSlot = SlotW'(TABLE_ENTRIES - 1);
  localparam logic [ProbeW-1:0]  MaxProbe = ProbeW'(TABLE_ENTRIES);
  localparam logic [LenW-1:0]    MaxLen   = LenW'(MAX_STORED_CHARS);
  localparam logic [CharsAw-1:0] RowStep  = CharsAw'(MAX_STORED_CHARS);

  typedef enum logic [3:0] {
    SClear,
    SIdle,
    SHash,
    SSetup,
    SMetaRd,
    SMetaChk,
    SCmpRd,
    SCmpChk,
    SCopyRd,
    SCopyWr,
    SMetaWr
  } state_e;

  state_e           state_q;
  logic [LenW-1:0]  len_q;
  logic [LenW-1:0]  wlen_q;
  logic             last_q;
  logic             op_q;
  logic [TokW-1:0]  tok_q;
  logic [TokW-1:0]  hit_tok_q;
  logic [SlotW-1:0] slot_q;
  logic [CharsAw-1:0] base_q;
  logic [ProbeW-1:0]  probes_q;
  logic [BufAw-1:0]   idx_q;
  logic               done_q;
  status_e            status_q;
  logic [TokW-1:0]    found_q;

  logic             accept;
  hash_req_t        hash_req;
  logic [SlotW-1:0] hash;

  logic             wbuf_we;
  logic [CharW-1:0] wbuf_rdata;
  logic             meta_we;
  logic [SlotW-1:0] meta_waddr;
  logic [MetaW-1:0] meta_wdata;
  logic [MetaW-1:0] meta_rdata;
  logic             chars_we;
  logic [CharsAw-1:0] chars_addr;
  logic [CharW-1:0]   chars_rdata;

  logic             meta_occ;
  logic [SLenW-1:0] meta_len;
  logic [TokW-1:0]  meta_tok;
  logic [SLenW-1:0] store_len;
  logic [LenW-1:0]  idx_ext;
  logic             cmp_last;
  logic             copy_last;
  logic [SlotW-1:0] slot_next;
  logic [CharsAw-1:0] base_next;

  assign accept = start && !busy;
  assign busy   = (state_q != SIdle);

  // hash unit
  always_comb begin
    hash_req.step      = accept;
    hash_req.clear     = (state_q == SSetup);
    hash_req.char_code = char_code_i;
  end

  khtl_hash #(
    .Entries(TABLE_ENTRIES)
  ) u_hash (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (hash_req),
    .hash_o(hash)
  );

  // word buffer: written on accept for the first MAX_STORED_CHARS characters, read by index during compare and copy
  assign wbuf_we = accept && (len_q < MaxLen);

  khtl_ram #(
    .Width(CharW),
    .Depth(MAX_STORED_CHARS)
  ) u_wbuf (
    .clk_i  (clk_i),
    .we_i   (wbuf_we),
    .waddr_i(len_q[BufAw-1:0]),
    .wdata_i(char_code_i),
    .raddr_i(idx_q),
    .rdata_o(wbuf_rdata)
  );

  // slot metadata: occupied, stored length, token
  assign store_len  = (wlen_q > MaxLen) ? SLenW'(MAX_STORED_CHARS) : wlen_q[SLenW-1:0];
  assign meta_we    = (state_q == SClear) || (state_q == SMetaWr);
  assign meta_waddr = slot_q;
  assign meta_wdata = (state_q == SClear) ? '0 : {1'b1, store_len, tok_q};

  khtl_ram #(
    .Width(MetaW),
    .Depth(TABLE_ENTRIES)
  ) u_meta (
    .clk_i  (clk_i),
    .we_i   (meta_we),
    .waddr_i(meta_waddr),
    .wdata_i(meta_wdata),
    .raddr_i(slot_q),
    .rdata_o(meta_rdata)
  );

  assign meta_occ = meta_rdata[MetaW-1];
  assign meta_len = meta_rdata[TokW +: SLenW];
  assign meta_tok = meta_rdata[TokW-1:0];

  // stored characters, one row per slot
  assign chars_we   = (state_q == SCopyWr);
  assign chars_addr = base_q + CharsAw'(idx_q);

  khtl_ram #(
    .Width(CharW),
    .Depth(CharsD)
  ) u_chars (
    .clk_i  (clk_i),
    .we_i   (chars_we),
    .waddr_i(chars_addr),
    .wdata_i(wbuf_rdata),
    .raddr_i(chars_addr),
    .rdata_o(chars_rdata)
  );

  // probe and index helpers
  assign idx_ext   = LenW'(idx_q);
  assign cmp_last  = (idx_ext == wlen_q - LenW'(1));
  assign copy_last = (idx_ext == LenW'(store_len) - LenW'(1));
  assign slot_next = (slot_q == LastSlot) ? '0 : slot_q + SlotW'(1);
  assign base_next = (slot_q == LastSlot) ? '0 : base_q + RowStep;

  // sequencer and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SClear;
      len_q     <= '0;
      wlen_q    <= '0;
      last_q    <= 1'b0;
      op_q      <= 1'b0;
      tok_q     <= '0;
      hit_tok_q <= '0;
      slot_q    <= '0;
      base_q    <= '0;
      probes_q  <= '0;
      idx_q     <= '0;
      done_q    <= 1'b0;
      status_q  <= StMiss;
      found_q   <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        SClear: begin
          slot_q <= slot_next;
          if (slot_q == LastSlot) begin
            state_q <= SIdle;
          end
        end
        SIdle: begin
          if (accept) begin
            if (len_q <= MaxLen) begin
              len_q <= len_q + LenW'(1);
            end
            last_q  <= last_char_i;
            op_q    <= opcode_i;
            tok_q   <= token_code_i;
            state_q <= SHash;
          end
        end
        SHash: begin
          state_q <= last_q ? SSetup : SIdle;
        end
        SSetup: begin
          slot_q   <= hash;
          base_q   <= CharsAw'(32'(hash) * MAX_STORED_CHARS);
          probes_q <= '0;
          wlen_q   <= len_q;
          len_q    <= '0;
          if (!op_q && (len_q > MaxLen)) begin
            done_q   <= 1'b1;
            status_q <= StMiss;
            found_q  <= '0;
            state_q  <= SIdle;
          end else begin
            state_q <= SMetaRd;
          end
        end
        SMetaRd: begin
          state_q <= SMetaChk;
        end
        SMetaChk: begin
          idx_q <= '0;
          if ((probes_q == MaxProbe) || !meta_occ) begin
            if (op_q && (probes_q != MaxProbe)) begin
              state_q <= SCopyRd;
            end else begin
              done_q   <= 1'b1;
              status_q <= op_q ? StFull : StMiss;
              found_q  <= '0;
              state_q  <= SIdle;
            end
          end else if (!op_q && (LenW'(meta_len) == wlen_q)) begin
            hit_tok_q <= meta_tok;
            state_q   <= SCmpRd;
          end else begin
            // step to the next slot
            slot_q   <= slot_next;
            base_q   <= base_next;
            probes_q <= probes_q + ProbeW'(1);
            state_q  <= SMetaRd;
          end
        end
        SCmpRd: begin
          state_q <= SCmpChk;
        end
        SCmpChk: begin
          if (wbuf_rdata != chars_rdata) begin
            slot_q   <= slot_next;
            base_q   <= base_next;
            probes_q <= probes_q + ProbeW'(1);
            state_q  <= SMetaRd;
          end else if (cmp_last) begin
            done_q   <= 1'b1;
            status_q <= StHit;
            found_q  <= hit_tok_q;
            state_q  <= SIdle;
          end else begin
            idx_q   <= idx_q + BufAw'(1);
            state_q <= SCmpRd;
          end
        end
        SCopyRd: begin
          state_q <= SCopyWr;
        end
        SCopyWr: begin
          if (copy_last) begin
            state_q <= SMetaWr;
          end else begin
            idx_q   <= idx_q + BufAw'(1);
            state_q <= SCopyRd;
          end
        end
        SMetaWr: begin
          done_q   <= 1'b1;
          status_q <= StInserted;
          found_q  <= '0;
          state_q  <= SIdle;
        end
        default: begin
          state_q <= SIdle;
        end
      endcase
    end
  end

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign found_token_o = found_q;

  // every accepted character passes through the hash fold
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("accepted request not followed by hash fold");

  // a result only ends a word operation
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy) && !busy)
    else $error("result without preceding word operation");

  // token is zero unless the lookup hit
  a_token_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != StHit)) |-> (found_token_o == '0))
    else $error("nonzero token on a non-hit result");

  // probing never passes the table size
  a_probe_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    probes_q <= MaxProbe)
    else $error("probe count beyond table size");

  // the slot table is only written while clearing or finishing an insert
  a_meta_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (meta_we && (state_q == SMetaWr)) |=> (done_o && (status_o == StInserted)))
    else $error("slot write without insert result");

endmodule

FILE: src/khtl_ram.sv
module khtl_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64,
  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // one write port, registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: src/khtl_hash.sv
module khtl_hash #(
  parameter int unsigned Entries = 64,
  localparam int unsigned SlotW = $clog2(Entries)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  khtl_pkg::hash_req_t req_i,
  output logic [SlotW-1:0]    hash_o
);

  import khtl_pkg::*;

  localparam int unsigned RedW = SlotW + 1;
  localparam int unsigned SumW = SlotW + 2;
  localparam logic [RedW-1:0] EntriesR = RedW'(Entries);
  localparam logic [SumW-1:0] EntriesS = SumW'(Entries);

  logic [SlotW-1:0] hash_q;
  logic             fold_q;
  logic [RedW-1:0]  h32_d, chm_d;
  logic [SlotW-1:0] h32_q, chm_q;
  logic [SumW-1:0]  sum;
  logic [SumW-1:0]  sum_r1;
  logic [SumW-1:0]  sum_r2;

  // first half: hash*32 mod n and char mod n, one doubling step per bit
  always_comb begin
    h32_d = {1'b0, hash_q};
    for (int k = 0; k < HashShift; k++) begin
      h32_d = {h32_d[RedW-2:0], 1'b0};
      if (h32_d >= EntriesR) begin
        h32_d = h32_d - EntriesR;
      end
    end
    chm_d = '0;
    for (int k = CharW - 1; k >= 0; k--) begin
      chm_d = {chm_d[RedW-2:0], req_i.char_code[k]};
      if (chm_d >= EntriesR) begin
        chm_d = chm_d - EntriesR;
      end
    end
  end

  // second half: h32 + chm - hash, brought back below n
  always_comb begin
    sum    = SumW'(h32_q) + SumW'(chm_q) + EntriesS - SumW'(hash_q);
    sum_r1 = (sum >= EntriesS) ? sum - EntriesS : sum;
    sum_r2 = (sum_r1 >= EntriesS) ? sum_r1 - EntriesS : sum_r1;
  end

  // partial terms
  always_ff @(posedge clk_i) begin
    if (req_i.step) begin
      h32_q <= h32_d[SlotW-1:0];
      chm_q <= chm_d[SlotW-1:0];
    end
  end

  // running hash
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= '0;
      fold_q <= 1'b0;
    end else begin
      fold_q <= req_i.step;
      if (req_i.clear) begin
        hash_q <= '0;
      end else if (fold_q) begin
        hash_q <= sum_r2[SlotW-1:0];
      end
    end
  end

  assign hash_o = hash_q;

endmodule
